### sv/sexpr_lexer_fsm_defines.svh
// Assertion macros used by the checker file of the scanner.
`ifndef SEXPR_LEXER_FSM_DEFINES_SVH
`define SEXPR_LEXER_FSM_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLX_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("sexpr lexer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SLX_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sexpr lexer check failed");

`endif

### sv/slx_pkg.sv
`default_nettype none

package slx_pkg;

  localparam int unsigned KIND_W = 3;

  localparam logic [KIND_W-1:0] KIND_OPEN   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CLOSE  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_IDENT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_INT    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DEC    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_STRING = 3'd5;
  localparam logic [KIND_W-1:0] KIND_ERR    = 3'd6;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_QUERY = 8'h3F;

  function automatic logic is_letter(logic [7:0] c);
    return (c inside {[8'd65:8'd90]}) || (c inside {[8'd97:8'd122]});
  endfunction

  function automatic logic is_numeral(logic [7:0] c);
    return c inside {[8'd48:8'd57]};
  endfunction

  function automatic logic is_name_char(logic [7:0] c);
    return is_letter(c) || is_numeral(c) || (c inside {CH_MINUS, CH_QUERY, CH_BANG});
  endfunction

endpackage

`default_nettype wire

### sv/slx_scanner.sv
`default_nettype none

module slx_scanner #(
  parameter int unsigned POS_BITS  = 32,
  parameter int unsigned LINE_BITS = 24,
  parameter int unsigned RES_W     = slx_pkg::KIND_W + 2 * POS_BITS + LINE_BITS + 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             fire_i,
  input  wire logic [7:0]       byte_i,
  input  wire logic             last_i,
  output logic      [1:0]       nres_o,
  output logic      [RES_W-1:0] res0_o,
  output logic      [RES_W-1:0] res1_o
);
  import slx_pkg::*;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_NAME    = 3'd1;
  localparam logic [2:0] ST_INT     = 3'd2;
  localparam logic [2:0] ST_DEC     = 3'd3;
  localparam logic [2:0] ST_COMMENT = 3'd4;
  localparam logic [2:0] ST_STRING  = 3'd5;
  localparam logic [2:0] ST_HALT    = 3'd6;

  logic [2:0]           state_q, state_d;
  logic [LINE_BITS-1:0] line_q, line_d;
  logic [POS_BITS-1:0]  begin_q, begin_d;
  logic [POS_BITS-1:0]  pos_q, pos_next;
  logic                 skip_q, skip_d;

  logic                 ea, eb, rescan;
  logic [KIND_W-1:0]    ek, bk;
  logic [POS_BITS-1:0]  es, ee;

  always_comb begin
    pos_next = pos_q + POS_BITS'(1);
    state_d  = state_q;
    line_d   = line_q;
    begin_d  = begin_q;
    skip_d   = skip_q;
    ea       = 1'b0;
    eb       = 1'b0;
    ek       = KIND_IDENT;
    bk       = KIND_OPEN;
    es       = begin_q;
    ee       = pos_q;
    rescan   = 1'b0;
    if (state_q == ST_HALT) begin
      state_d = ST_HALT;
    end else if (skip_q) begin
      if (last_i) begin
        skip_d = 1'b0;
      end
    end else if (byte_i == CH_NUL) begin
      skip_d = !last_i;
    end else begin
      case (state_q)
        ST_NAME: begin
          if (!is_name_char(byte_i)) begin
            ea     = 1'b1;
            ek     = KIND_IDENT;
            rescan = 1'b1;
          end
        end
        ST_INT: begin
          if (byte_i == CH_DOT) begin
            state_d = ST_DEC;
          end else if (!is_numeral(byte_i)) begin
            ea     = 1'b1;
            ek     = KIND_INT;
            rescan = 1'b1;
          end
        end
        ST_DEC: begin
          if (!is_numeral(byte_i)) begin
            ea     = 1'b1;
            ek     = KIND_DEC;
            rescan = 1'b1;
          end
        end
        ST_STRING: begin
          if (byte_i == CH_QUOTE) begin
            ea      = 1'b1;
            ek      = KIND_STRING;
            ee      = pos_next;
            state_d = ST_IDLE;
          end else if (byte_i == CH_LF) begin
            ea      = 1'b1;
            ek      = KIND_ERR;
            state_d = ST_HALT;
          end
        end
        ST_COMMENT: begin
          if (byte_i == CH_LF) begin
            state_d = ST_IDLE;
          end
        end
        default: begin
          rescan = 1'b1;
        end
      endcase

      if (rescan) begin
        state_d = ST_IDLE;
        if (byte_i == CH_SEMI) begin
          state_d = ST_COMMENT;
        end else if (byte_i == CH_OPEN) begin
          eb = 1'b1;
          bk = KIND_OPEN;
        end else if (byte_i == CH_CLOSE) begin
          eb = 1'b1;
          bk = KIND_CLOSE;
        end else if (is_letter(byte_i)) begin
          state_d = ST_NAME;
          begin_d = pos_q;
        end else if (is_numeral(byte_i)) begin
          state_d = ST_INT;
          begin_d = pos_q;
        end else if (byte_i == CH_QUOTE) begin
          state_d = ST_STRING;
          begin_d = pos_q;
        end
      end

      if (byte_i == CH_LF && line_q != {LINE_BITS{1'b1}}) begin
        line_d = line_q + LINE_BITS'(1);
      end
    end
  end

  // Results are packed as {last, line, end, start, kind}.
  always_comb begin
    nres_o = {ea & eb, ea ^ eb};
    res1_o = {1'b1, line_q, pos_next, pos_q, bk};
    if (ea) begin
      res0_o = {!eb, line_q, ee, es, ek};
    end else begin
      res0_o = {1'b1, line_q, pos_next, pos_q, bk};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      line_q  <= LINE_BITS'(1);
      begin_q <= '0;
      pos_q   <= '0;
      skip_q  <= 1'b0;
    end else if (fire_i) begin
      state_q <= state_d;
      line_q  <= line_d;
      begin_q <= begin_d;
      pos_q   <= pos_next;
      skip_q  <= skip_d;
    end
  end

endmodule

`default_nettype wire

### sv/slx_out_buf.sv
`default_nettype none

module slx_out_buf #(
  parameter int unsigned RES_W = 93
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [1:0]       push_cnt_i,
  input  wire logic [RES_W-1:0] push0_i,
  input  wire logic [RES_W-1:0] push1_i,
  input  wire logic             pop_i,
  output logic                  head_valid_o,
  output logic      [RES_W-1:0] head_o,
  output logic      [1:0]       free_o
);

  logic             a_valid_q, a_valid_d, b_valid_q, b_valid_d;
  logic [RES_W-1:0] a_q, a_d, b_q, b_d;
  logic             rav, rbv;
  logic [RES_W-1:0] ra;

  always_comb begin
    rav    = pop_i ? b_valid_q : a_valid_q;
    ra     = pop_i ? b_q : a_q;
    rbv    = pop_i ? 1'b0 : b_valid_q;
    free_o = 2'd2 - ({1'b0, rav} + {1'b0, rbv});

    a_valid_d = rav || (push_cnt_i != 2'd0);
    a_d       = rav ? ra : push0_i;
    if (rav) begin
      b_valid_d = rbv || (push_cnt_i != 2'd0);
      b_d       = rbv ? b_q : push0_i;
    end else begin
      b_valid_d = (push_cnt_i == 2'd2);
      b_d       = push1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      b_valid_q <= b_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
  end

  assign head_valid_o = a_valid_q;
  assign head_o       = a_q;

endmodule

`default_nettype wire

### sv/sexpr_lexer_fsm.sv
// S-expression scanner taking one source byte per beat and returning one token per beat.
// A byte is held in an input register and scanned there, updating the scanner state and
// writing its zero, one or two tokens into a two-entry result buffer; a new byte is taken
// in every cycle as long as that buffer has room for its tokens, so the sustained rate is
// one byte per clock, and a byte that ends one token and opens a parenthesis yields two
// tokens. A token's closing byte waits in the input register until the buffer has room, and
// the token then goes out from the buffer register. Positions count every byte and
// wrap; the line count saturates. A zero byte discards the rest of its buffer, and a newline
// inside a string reports an error token after which the block consumes bytes but reports
// nothing more until reset.
`default_nettype none

module sexpr_lexer_fsm #(
  parameter int unsigned POS_BITS  = 32,
  parameter int unsigned LINE_BITS = 24,
  localparam int unsigned OUT_W    = ((2 * POS_BITS + LINE_BITS + 7) / 8) * 8
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [7:0]                 s_axis_tdata,  // data_byte
  input  wire logic                       s_axis_tlast,  // buffer_last
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic      [OUT_W-1:0]           m_axis_tdata,  // start_pos, end_pos, line_number
  output logic      [slx_pkg::KIND_W-1:0] m_axis_tuser,  // token_kind
  output logic                            m_axis_tlast   // last_result
);
  import slx_pkg::*;

  localparam int unsigned RES_W = KIND_W + 2 * POS_BITS + LINE_BITS + 1;
  localparam int unsigned PAY_W = 2 * POS_BITS + LINE_BITS;

  logic             in_valid_q;
  logic [7:0]       in_byte_q;
  logic             in_last_q;
  logic             fire;
  logic             pop;
  logic [1:0]       nres;
  logic [1:0]       free;
  logic [1:0]       push_cnt;
  logic [RES_W-1:0] res0, res1, head;

  assign pop           = m_axis_tvalid && m_axis_tready;
  assign fire          = in_valid_q && (nres <= free);
  assign s_axis_tready = !in_valid_q || fire;
  assign push_cnt      = fire ? nres : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  slx_scanner #(
    .POS_BITS (POS_BITS),
    .LINE_BITS(LINE_BITS),
    .RES_W    (RES_W)
  ) u_scanner (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .fire_i(fire),
    .byte_i(in_byte_q),
    .last_i(in_last_q),
    .nres_o(nres),
    .res0_o(res0),
    .res1_o(res1)
  );

  slx_out_buf #(
    .RES_W(RES_W)
  ) u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (push_cnt),
    .push0_i     (res0),
    .push1_i     (res1),
    .pop_i       (pop),
    .head_valid_o(m_axis_tvalid),
    .head_o      (head),
    .free_o      (free)
  );

  assign m_axis_tuser = head[KIND_W-1:0];
  assign m_axis_tdata = OUT_W'(head[KIND_W +: PAY_W]);
  assign m_axis_tlast = head[RES_W-1];

endmodule

`default_nettype wire

### sv/sexpr_lexer_fsm_chk.sv
`default_nettype none
`include "sexpr_lexer_fsm_defines.svh"

module sexpr_lexer_fsm_chk #(
  parameter int unsigned POS_BITS  = 32,
  parameter int unsigned LINE_BITS = 24,
  localparam int unsigned OUT_W    = ((2 * POS_BITS + LINE_BITS + 7) / 8) * 8
) (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       s_axis_tvalid,
  input wire logic                       s_axis_tready,
  input wire logic [7:0]                 s_axis_tdata,
  input wire logic                       s_axis_tlast,
  input wire logic                       m_axis_tvalid,
  input wire logic                       m_axis_tready,
  input wire logic [OUT_W-1:0]           m_axis_tdata,
  input wire logic [slx_pkg::KIND_W-1:0] m_axis_tuser,
  input wire logic                       m_axis_tlast
);
  import slx_pkg::*;

  logic                halted_q;
  logic [POS_BITS-1:0] start_pos, end_pos, start_plus_one;
  logic                in_beat;

  assign in_beat        = s_axis_tvalid && s_axis_tready && (s_axis_tdata != CH_NUL);
  assign start_pos      = m_axis_tdata[POS_BITS-1:0];
  assign end_pos        = m_axis_tdata[2*POS_BITS-1:POS_BITS];
  assign start_plus_one = start_pos + POS_BITS'(1);

  // Once an error token has been delivered nothing more is reported.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      halted_q <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready && m_axis_tuser == KIND_ERR) begin
      halted_q <= 1'b1;
    end
  end

  `SLX_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
  `SLX_ASSERT_IMP(a_kind_range, clk_i, rst_ni, m_axis_tvalid, m_axis_tuser <= KIND_ERR)
  `SLX_ASSERT_IMP(a_halt_quiet, clk_i, rst_ni, halted_q, !m_axis_tvalid)
  `SLX_ASSERT_IMP(a_paren_len, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser == KIND_OPEN || m_axis_tuser == KIND_CLOSE), end_pos == start_plus_one && m_axis_tlast)
  `SLX_ASSERT_IMP(a_in_known, clk_i, rst_ni, in_beat, !$isunknown(s_axis_tlast))

endmodule

bind sexpr_lexer_fsm sexpr_lexer_fsm_chk #(
  .POS_BITS (POS_BITS),
  .LINE_BITS(LINE_BITS)
) u_chk (.*);

`default_nettype wire
